>>> rtl/psi_pkg.sv
package psi_pkg;

   localparam int MaxWidth   = 128;
   localparam int MaxHeight  = 128;
   localparam int ChanBits   = 16;
   localparam int PixBits    = 4 * ChanBits;
   localparam int MemDepth   = 21844;
   localparam int AddrBits   = 15;
   localparam int CoordBits  = 7;
   localparam int DimBits    = 8;
   localparam int LevelLimit = 16;
   localparam int LevelBits  = 4;
   localparam logic [DimBits-1:0] ResetWidth  = 8'd128;
   localparam logic [DimBits-1:0] ResetHeight = 8'd128;
   localparam logic [DimBits-1:0] ResetPasses = 8'd30;
   localparam logic [AddrBits-1:0] Level1Base = 15'd16384;

   localparam logic [1:0] CsrWidth  = 2'd0;
   localparam logic [1:0] CsrHeight = 2'd1;
   localparam logic [1:0] CsrPasses = 2'd2;

   localparam logic OpLoad = 1'b0;
   localparam logic OpRead = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [CoordBits-1:0] col;
      logic [CoordBits-1:0] row;
      logic [15:0]          red_in;
      logic [15:0]          green_in;
      logic [15:0]          blue_in;
      logic [15:0]          alpha_in;
      logic                 hole;
      logic                 last_load;
   } req_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
      logic [15:0] alpha_out;
   } rsp_type;

   // memory access request from the sequencer
   typedef struct packed {
      logic                wr;
      logic [AddrBits-1:0] addr;
      logic [PixBits-1:0]  pix;
      logic                hole;
   } mem_cmd_type;

   // truncating division of sums by 1..4; divide by three with a Q19 reciprocal,
   // exact for every sum of up to four channels
   function automatic logic [ChanBits+1:0] div_small(input logic [ChanBits+1:0] s,
                                                      input logic [2:0] n);
      logic [ChanBits+1:0] q;
      begin
         q = s;
         case (n)
            3'd2: q = s >> 1;
            3'd3: q = (ChanBits+2)'(((36'(s) * 36'd174763) >> 19));
            3'd4: q = s >> 2;
            default: q = s;
         endcase
         return q;
      end
   endfunction

endpackage

>>> rtl/psi_mem.sv
module psi_mem (
   input  logic                          clock,
   input  psi_pkg::mem_cmd_type          cmd,
   output logic [psi_pkg::PixBits-1:0]   rd_pix,
   output logic                          rd_hole
);

   logic [psi_pkg::PixBits-1:0] pix_mem [psi_pkg::MemDepth];
   logic                        hole_mem [psi_pkg::MemDepth];

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         pix_mem[cmd.addr]  <= cmd.pix;
         hole_mem[cmd.addr] <= cmd.hole;
      end
      rd_pix  <= pix_mem[cmd.addr];
      rd_hole <= hole_mem[cmd.addr];
   end

endmodule

>>> rtl/psi_seq.sv
// Fill sequencer: every step is a single memory access; a shared 4-lane
// accumulator sums up to four children or neighbours and divides by the count.
module psi_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [psi_pkg::DimBits-1:0]   cfg_w,
   input  logic [psi_pkg::DimBits-1:0]   cfg_h,
   input  logic [psi_pkg::DimBits-1:0]   cfg_passes,
   input  logic [psi_pkg::PixBits-1:0]   rd_pix,
   input  logic                          rd_hole,
   output psi_pkg::mem_cmd_type          cmd,
   output logic                          busy
);

   typedef enum logic [3:0] {
      IDLE, SETUP, SH_RD, SH_ACC, SH_WR, SM_CHK, SM_CHKW, SM_RD, SM_ACC, SM_WR,
      EX_CHK, EX_CHKW, EX_RD, EX_WR, NEXT
   } state_type;

   localparam int AB = psi_pkg::AddrBits;
   localparam int CB = psi_pkg::ChanBits;
   localparam int DB = psi_pkg::DimBits;
   localparam int PixBits_l = psi_pkg::PixBits;

   state_type state_ff, state_in;
   logic [DB-1:0] lw_ff [psi_pkg::LevelLimit];
   logic [DB-1:0] lh_ff [psi_pkg::LevelLimit];
   logic [AB-1:0] lo_ff [psi_pkg::LevelLimit];
   logic [DB-1:0] lw_in, lh_in;
   logic [AB-1:0] lo_in;
   logic [psi_pkg::LevelBits-1:0] lvl_ff, lvl_in;
   logic [DB-1:0] x_ff, x_in, y_ff, y_in, pass_ff, pass_in;
   logic [2:0]    k_ff, k_in, cnt_ff, cnt_in;
   logic          all_ff, all_in;
   logic [CB+1:0] sum_ff [4];
   logic [CB+1:0] sum_in [4];
   logic [1:0]    hold_ff, hold_in;
   logic [DB-1:0] cw, ch, fw, fh, nx, ny, cx, cy;
   logic          inb, nb_ok;
   logic [PixBits_l-1:0] avg_w;

   always_comb begin
      cw = lw_ff[lvl_ff];
      ch = lh_ff[lvl_ff];
      fw = (lvl_ff == '0) ? cw : lw_ff[lvl_ff - 1'b1];
      fh = (lvl_ff == '0) ? ch : lh_ff[lvl_ff - 1'b1];
      // shrink child coordinates, clamped
      cx = {x_ff[DB-2:0], 1'b0} + DB'(k_ff[0]);
      cy = {y_ff[DB-2:0], 1'b0} + DB'(k_ff[1]);
      inb = (cx < fw) && (cy < fh);
      if (cx >= fw) cx = fw - 1'b1;
      if (cy >= fh) cy = fh - 1'b1;
      // smoothing neighbours: up, left, right, down
      nx = x_ff; ny = y_ff; nb_ok = 1'b0;
      case (k_ff[1:0])
         2'd0: begin ny = y_ff - 1'b1; nb_ok = (y_ff != '0); end
         2'd1: begin nx = x_ff - 1'b1; nb_ok = (x_ff != '0); end
         2'd2: begin nx = x_ff + 1'b1; nb_ok = (x_ff + 1'b1 < cw); end
         default: begin ny = y_ff + 1'b1; nb_ok = (y_ff + 1'b1 < ch); end
      endcase
      avg_w = '0;
      for (int c = 0; c < 4; c++)
         avg_w[c*CB +: CB] = (cnt_ff == '0) ? '0 : CB'(psi_pkg::div_small(sum_ff[c], cnt_ff));
   end

   // address of (px,py) at level l: offset + py*stride + px
   function automatic logic [AB-1:0] at_addr(input logic [AB-1:0] off,
                                             input logic [DB-1:0] st,
                                             input logic [DB-1:0] px,
                                             input logic [DB-1:0] py);
      return off + AB'(py * st) + AB'(px);
   endfunction

   logic [DB-1:0] stf, stc, stp;
   assign stf = (lvl_ff == '0) ? DB'(psi_pkg::MaxWidth) : lw_ff[lvl_ff];
   assign stc = (lvl_ff == '0) ? DB'(psi_pkg::MaxWidth) : cw;
   assign stp = lw_ff[lvl_ff + 1'b1];

   always_comb begin
      state_in = state_ff; lvl_in = lvl_ff;
      x_in = x_ff; y_in = y_ff; pass_in = pass_ff; k_in = k_ff; cnt_in = cnt_ff;
      all_in = all_ff; hold_in = hold_ff;
      lw_in = '0; lh_in = '0; lo_in = '0;
      for (int c = 0; c < 4; c++) sum_in[c] = sum_ff[c];
      cmd = '0;
      unique case (state_ff)
         IDLE: if (start) begin
            state_in = SETUP; lvl_in = '0;
         end
         SETUP: begin
            // level lvl_ff is built; decide whether to add a coarser one
            if (cw > 2 && ch > 2 && lvl_ff != 4'(psi_pkg::LevelLimit - 1)) begin
               lvl_in = lvl_ff + 1'b1;
               x_in = '0; y_in = '0; k_in = '0; cnt_in = '0; all_in = 1'b1;
               for (int c = 0; c < 4; c++) sum_in[c] = '0;
               state_in = SH_RD;
            end else begin
               pass_in = '0; x_in = '0; y_in = '0;
               state_in = (cfg_passes == '0) ? NEXT : SM_CHK;
            end
         end
         SH_RD: begin
            cmd.addr = at_addr((lvl_ff == 4'd1) ? '0 : lo_ff[lvl_ff - 1'b1],
                               (lvl_ff == 4'd1) ? DB'(psi_pkg::MaxWidth) : fw, cx, cy);
            hold_in[0] = inb;
            state_in = SH_ACC;
         end
         SH_ACC: begin
            // only in-bounds children vote on the coarse hole flag
            if (hold_ff[0]) all_in = all_ff & rd_hole;
            if (!rd_hole) begin
               for (int c = 0; c < 4; c++) sum_in[c] = sum_ff[c] + (CB+2)'(rd_pix[c*CB +: CB]);
               cnt_in = cnt_ff + 1'b1;
            end
            if (k_ff == 3'd3) state_in = SH_WR;
            else begin k_in = k_ff + 1'b1; state_in = SH_RD; end
         end
         SH_WR: begin
            cmd.wr = 1'b1;
            cmd.addr = at_addr(lo_ff[lvl_ff], cw, x_ff, y_ff);
            cmd.pix = avg_w;
            cmd.hole = all_ff;
            k_in = '0; cnt_in = '0; all_in = 1'b1;
            for (int c = 0; c < 4; c++) sum_in[c] = '0;
            state_in = SH_RD;
            if (x_ff + 1'b1 < cw) x_in = x_ff + 1'b1;
            else begin
               x_in = '0;
               if (y_ff + 1'b1 < ch) y_in = y_ff + 1'b1;
               else state_in = SETUP;
            end
         end
         SM_CHK: begin
            cmd.addr = at_addr(lo_ff[lvl_ff], stc, x_ff, y_ff);
            state_in = SM_CHKW;
         end
         SM_CHKW: begin
            k_in = '0; cnt_in = '0;
            for (int c = 0; c < 4; c++) sum_in[c] = '0;
            state_in = rd_hole ? SM_RD : SM_WR;
            hold_in[0] = rd_hole;
         end
         SM_RD: begin
            cmd.addr = at_addr(lo_ff[lvl_ff], stc, nx, ny);
            hold_in[1] = nb_ok;
            state_in = SM_ACC;
         end
         SM_ACC: begin
            if (hold_ff[1]) begin
               for (int c = 0; c < 4; c++) sum_in[c] = sum_ff[c] + (CB+2)'(rd_pix[c*CB +: CB]);
               cnt_in = cnt_ff + 1'b1;
            end
            if (k_ff == 3'd3) state_in = SM_WR;
            else begin k_in = k_ff + 1'b1; state_in = SM_RD; end
         end
         SM_WR: begin
            // write only holes that have neighbours; then advance raster
            if (hold_ff[0] && cnt_ff != '0) begin
               cmd.wr = 1'b1;
               cmd.addr = at_addr(lo_ff[lvl_ff], stc, x_ff, y_ff);
               cmd.pix = avg_w;
               cmd.hole = 1'b1;
            end
            state_in = SM_CHK;
            if (x_ff + 1'b1 < cw) x_in = x_ff + 1'b1;
            else begin
               x_in = '0;
               if (y_ff + 1'b1 < ch) y_in = y_ff + 1'b1;
               else begin
                  y_in = '0;
                  if (pass_ff + 1'b1 < cfg_passes) pass_in = pass_ff + 1'b1;
                  else state_in = NEXT;
               end
            end
         end
         NEXT: begin
            if (lvl_ff == '0) state_in = IDLE;
            else begin
               lvl_in = lvl_ff - 1'b1; x_in = '0; y_in = '0; pass_in = '0;
               state_in = EX_CHK;
            end
         end
         EX_CHK: begin
            cmd.addr = at_addr(lo_ff[lvl_ff], stf, x_ff, y_ff);
            state_in = EX_CHKW;
         end
         EX_CHKW: state_in = rd_hole ? EX_RD : EX_WR;
         EX_RD: begin
            cmd.addr = at_addr(lo_ff[lvl_ff + 1'b1], stp, x_ff >> 1, y_ff >> 1);
            hold_in[0] = 1'b1;
            state_in = EX_WR;
         end
         EX_WR: begin
            if (hold_ff[0]) begin
               cmd.wr = 1'b1;
               cmd.addr = at_addr(lo_ff[lvl_ff], stf, x_ff, y_ff);
               cmd.pix = rd_pix;
               cmd.hole = 1'b1;
            end
            hold_in[0] = 1'b0;
            state_in = EX_CHK;
            if (x_ff + 1'b1 < cw) x_in = x_ff + 1'b1;
            else begin
               x_in = '0;
               if (y_ff + 1'b1 < ch) y_in = y_ff + 1'b1;
               else begin
                  y_in = '0;
                  state_in = (cfg_passes == '0) ? NEXT : SM_CHK;
               end
            end
         end
         default: state_in = IDLE;
      endcase
      if (state_ff == EX_CHKW) hold_in[0] = 1'b0;
      // geometry of the next coarser level
      lw_in = DB'((9'(cw) + 9'd1) >> 1);
      lh_in = DB'((9'(ch) + 9'd1) >> 1);
      lo_in = lo_ff[lvl_ff] + ((lvl_ff == '0) ? '0 : AB'(cw * ch));
   end

   assign busy = (state_ff != IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         lvl_ff <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff <= lvl_in;
      end
      x_ff <= x_in; y_ff <= y_in; pass_ff <= pass_in; k_ff <= k_in;
      cnt_ff <= cnt_in; all_ff <= all_in; hold_ff <= hold_in;
      for (int c = 0; c < 4; c++) sum_ff[c] <= sum_in[c];
      if (state_ff == IDLE && start) begin
         lw_ff[0] <= (cfg_w == '0) ? 8'd1 : ((cfg_w > 8'd128) ? 8'd128 : cfg_w);
         lh_ff[0] <= (cfg_h == '0) ? 8'd1 : ((cfg_h > 8'd128) ? 8'd128 : cfg_h);
         lo_ff[0] <= '0;
      end
      if (state_ff == SETUP && state_in == SH_RD) begin
         lw_ff[lvl_in] <= lw_in;
         lh_ff[lvl_in] <= lh_in;
         lo_ff[lvl_in] <= (lvl_ff == '0) ? psi_pkg::Level1Base : lo_in;
      end
   end

endmodule

>>> rtl/pyramid_smooth_inpainting.sv
// Loads are accepted one per cycle unless a fill runs or a read is outstanding;
// a read's pixel is registered in the memory, then in rsp_ff, and no request is
// accepted until the response is taken. A load with last_load runs the pyramid
// fill, holding req_ready low: smoothing averages a hole's in-bounds neighbours,
// expansion copies each hole's parent, coarsening averages the known children.
// Reset clears control state and restores register defaults; pixel memory is not.
module pyramid_smooth_inpainting (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  psi_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psi_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   logic [7:0] width_ff, height_ff, passes_ff;
   logic       busy, rd_hole, start;
   logic [psi_pkg::PixBits-1:0] rd_pix;
   psi_pkg::mem_cmd_type seq_cmd, cmd;
   logic       pend_ff, pend_in, zero_ff, zero_in, rsp_valid_ff, rsp_valid_in;
   psi_pkg::rsp_type rsp_ff, rsp_in;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_ready = !busy && !pend_ff && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign start = accept && req_data.op == psi_pkg::OpLoad && req_data.last_load;

   always_comb begin
      cmd = seq_cmd;
      if (!busy) begin
         cmd.wr   = accept && req_data.op == psi_pkg::OpLoad;
         cmd.addr = {1'b0, req_data.row, req_data.col};
         cmd.pix  = {req_data.alpha_in, req_data.blue_in, req_data.green_in, req_data.red_in};
         cmd.hole = req_data.hole;
      end
      pend_in = accept && req_data.op == psi_pkg::OpRead;
      zero_in = 1'b0;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in = {rd_pix[63:48], rd_pix[47:32], rd_pix[31:16], rd_pix[15:0]};
      end
   end

   psi_mem u_mem (.clock(clock), .cmd(cmd), .rd_pix(rd_pix), .rd_hole(rd_hole));

   psi_seq u_seq (
      .clock(clock), .reset(reset), .start(start),
      .cfg_w(width_ff), .cfg_h(height_ff), .cfg_passes(passes_ff),
      .rd_pix(rd_pix), .rd_hole(rd_hole), .cmd(seq_cmd), .busy(busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= psi_pkg::ResetWidth;
         height_ff <= psi_pkg::ResetHeight;
         passes_ff <= psi_pkg::ResetPasses;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               psi_pkg::CsrWidth:  width_ff <= csr_data;
               psi_pkg::CsrHeight: height_ff <= csr_data;
               psi_pkg::CsrPasses: passes_ff <= csr_data;
               default: ;
            endcase
         end
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         zero_ff <= zero_in;
      end
      rsp_ff <= rsp_in;
   end

   // pixel packs red in the low lane
   assign rsp_data = '{red_out: rsp_ff.alpha_out, green_out: rsp_ff.blue_out,
                       blue_out: rsp_ff.green_out, alpha_out: rsp_ff.red_out};
   assign rsp_valid = rsp_valid_ff && !zero_ff;

endmodule
